// ===== design/four_neighbor_average_stencil_macros.svh =====
// Assertion macros for the four-neighbor average stencil.
// Used by the checker module; no other dependencies.
`ifndef FOUR_NEIGHBOR_AVERAGE_STENCIL_MACROS_SVH
`define FOUR_NEIGHBOR_AVERAGE_STENCIL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FNAS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil assertion failed");

// Next-cycle implication, disabled during reset.
`define FNAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil assertion failed");

`endif

// ===== design/fnas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the four-neighbor average stencil.
// No dependencies.
package fnas_pkg;

    localparam int ROW_BITS       = 16;
    localparam int WIDTH_BITS     = 12;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                emit;
        logic                last;
        logic [ROW_BITS-1:0] row;
    } pos_info_t;

endpackage

// ===== design/fnas_position.sv =====
`timescale 1ns / 1ps
// Grid size registers and row/column position counters of the stencil.
// Depends on fnas_pkg.
module fnas_position #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_BITS  = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fnas_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fnas_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               fire,
    output fnas_pkg::pos_info_t                pos,
    output logic [COL_BITS-1:0]                col,
    output logic [COL_BITS-1:0]                col_right
);

    logic [fnas_pkg::WIDTH_BITS-1:0] grid_width_reg;
    logic [fnas_pkg::ROW_BITS-1:0]   grid_height_reg;
    logic [COL_BITS-1:0]             col_count_reg;
    logic [COL_BITS-1:0]             col_count_next;
    logic [fnas_pkg::ROW_BITS-1:0]   row_count_reg;
    logic [fnas_pkg::ROW_BITS-1:0]   row_count_next;
    logic [COL_BITS-1:0]             last_col;
    logic [fnas_pkg::ROW_BITS-1:0]   last_row;
    logic [COL_BITS-1:0]             c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= fnas_pkg::WIDTH_BITS'(2048);
            grid_height_reg <= fnas_pkg::ROW_BITS'(2048);
        end
        else if (cfg_write)
        begin
            case (fnas_pkg::cfg_reg_t'(cfg_index))
                fnas_pkg::REG_GRID_WIDTH:
                    grid_width_reg <= cfg_data[fnas_pkg::WIDTH_BITS-1:0];
                fnas_pkg::REG_GRID_HEIGHT:
                    grid_height_reg <= cfg_data[fnas_pkg::ROW_BITS-1:0];
                default:
                    grid_width_reg <= grid_width_reg;
            endcase
        end
    end

    // clamp grid size
    always_comb
    begin
        if (grid_width_reg < fnas_pkg::WIDTH_BITS'(3))
            last_col = COL_BITS'(2);
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
            last_col = COL_BITS'(MAX_WIDTH - 1);
        else
            last_col = COL_BITS'(grid_width_reg - fnas_pkg::WIDTH_BITS'(1));

        if (grid_height_reg < fnas_pkg::ROW_BITS'(3))
            last_row = fnas_pkg::ROW_BITS'(2);
        else
            last_row = grid_height_reg - fnas_pkg::ROW_BITS'(1);

        c = (col_count_reg > last_col) ? last_col : col_count_reg;
    end

    always_comb
    begin
        pos.emit  = (row_count_reg >= fnas_pkg::ROW_BITS'(2)) && (row_count_reg <= last_row)
                    && (c != '0) && (c < last_col);
        pos.last  = (row_count_reg == last_row) && (c == last_col - COL_BITS'(1));
        pos.row   = row_count_reg - fnas_pkg::ROW_BITS'(1);
        col       = c;
        col_right = c + COL_BITS'(1);
    end

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (fire)
        begin
            if (c >= last_col)
            begin
                col_count_next = '0;
                row_count_next = (row_count_reg >= last_row) ? '0
                                 : row_count_reg + fnas_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_count_next = c + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

// ===== design/fnas_line_mem.sv =====
`timescale 1ns / 1ps
// Line store: one write port, two registered read ports, one entry per column.
// No dependencies.
module fnas_line_mem #(
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [DATA_BITS-1:0] rd_data_a,
    output logic [DATA_BITS-1:0] rd_data_b,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data
);

    localparam int DEPTH = 2 ** ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== design/fnas_stage.sv =====
`timescale 1ns / 1ps
// Sum stage and output register: adds the four neighbors, writes rows back.
// Depends on fnas_pkg.
module fnas_stage #(
    parameter int SAMPLE_BITS = 16,
    parameter int COL_BITS    = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [SAMPLE_BITS-1:0]       sample,
    input  fnas_pkg::pos_info_t          pos,
    input  logic [COL_BITS-1:0]          col,
    input  logic [2*SAMPLE_BITS-1:0]     rd_data_a,
    input  logic [2*SAMPLE_BITS-1:0]     rd_data_b,
    output logic                         hold,
    output logic                         wr_en,
    output logic [COL_BITS-1:0]          wr_addr,
    output logic [2*SAMPLE_BITS-1:0]     wr_data,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [SAMPLE_BITS+1:0]       average_q2,
    output logic [fnas_pkg::ROW_BITS-1:0] out_row,
    output logic [COL_BITS-1:0]          out_col,
    output logic                         frame_last
);

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [SAMPLE_BITS-1:0]    s1_sample_reg;
    fnas_pkg::pos_info_t       s1_pos_reg;
    logic [COL_BITS-1:0]       s1_col_reg;
    logic [SAMPLE_BITS-1:0]    left_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [SAMPLE_BITS+1:0]    avg_reg;
    logic [fnas_pkg::ROW_BITS-1:0] row_reg;
    logic [COL_BITS-1:0]       col_reg;
    logic                      last_reg;
    logic                      s1_adv;
    logic [SAMPLE_BITS-1:0]    up;
    logic [SAMPLE_BITS-1:0]    mid;
    logic [SAMPLE_BITS-1:0]    right;
    logic [SAMPLE_BITS+1:0]    sum;

    always_comb
    begin
        up    = rd_data_a[2*SAMPLE_BITS-1:SAMPLE_BITS];
        mid   = rd_data_a[SAMPLE_BITS-1:0];
        right = rd_data_b[SAMPLE_BITS-1:0];
        sum   = (SAMPLE_BITS+2)'(up) + (SAMPLE_BITS+2)'(left_reg)
              + (SAMPLE_BITS+2)'(right) + (SAMPLE_BITS+2)'(s1_sample_reg);

        s1_adv = s1_valid_reg && (!s1_pos_reg.emit || !out_valid_reg || !out_stall);
        hold   = s1_valid_reg && !s1_adv;

        wr_en   = s1_adv;
        wr_addr = s1_col_reg;
        wr_data = {mid, s1_sample_reg};

        s1_valid_next = fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        if (s1_adv && s1_pos_reg.emit)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_sample_reg <= sample;
            s1_pos_reg    <= pos;
            s1_col_reg    <= col;
        end
        if (s1_adv)
            left_reg <= mid;
        if (s1_adv && s1_pos_reg.emit)
        begin
            avg_reg  <= sum;
            row_reg  <= s1_pos_reg.row;
            col_reg  <= s1_col_reg;
            last_reg <= s1_pos_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign average_q2 = avg_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign frame_last = last_reg;

endmodule

// ===== design/four_neighbor_average_stencil.sv =====
`timescale 1ns / 1ps
// Top level of the four-neighbor average stencil (Jacobi four-point).
// Depends on fnas_pkg, fnas_position, fnas_line_mem, fnas_stage.
//
//   channel  handshake              payload
//   cfg      cfg_write              cfg_index, cfg_data
//   in       in_valid / in_stall    sample
//   out      out_valid / out_stall  average_q2, out_row, out_col, frame_last
//
// One item per cycle while in_stall is low. An accepted item passes the
// registered line store read, then the adder stage into the output register.
// Reset clears counters and valid flags; the line store needs no clearing.
// in_stall rises only while an unsent result waits under out_stall.
module four_neighbor_average_stencil #(
    parameter int  MAX_WIDTH   = 2048,
    parameter int  SAMPLE_BITS = 16,
    localparam int COL_BITS    = $clog2(MAX_WIDTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fnas_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fnas_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [SAMPLE_BITS+1:0]              average_q2,
    output logic [fnas_pkg::ROW_BITS-1:0]       out_row,
    output logic [COL_BITS-1:0]                 out_col,
    output logic                                frame_last
);

    logic                     fire;
    logic                     hold;
    fnas_pkg::pos_info_t      pos;
    logic [COL_BITS-1:0]      col;
    logic [COL_BITS-1:0]      col_right;
    logic [2*SAMPLE_BITS-1:0] rd_data_a;
    logic [2*SAMPLE_BITS-1:0] rd_data_b;
    logic                     wr_en;
    logic [COL_BITS-1:0]      wr_addr;
    logic [2*SAMPLE_BITS-1:0] wr_data;

    assign in_stall = hold;
    assign fire     = in_valid && !hold;

    fnas_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_BITS  (COL_BITS)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .pos       (pos),
        .col       (col),
        .col_right (col_right)
    );

    fnas_line_mem #(
        .ADDR_BITS (COL_BITS),
        .DATA_BITS (2 * SAMPLE_BITS)
    ) u_line_mem (
        .clk       (clk),
        .rd_en     (fire),
        .rd_addr_a (col),
        .rd_addr_b (col_right),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    fnas_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_BITS    (COL_BITS)
    ) u_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .sample     (sample),
        .pos        (pos),
        .col        (col),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .hold       (hold),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .average_q2 (average_q2),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

endmodule

// ===== design/fnas_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the four-neighbor average stencil, bound to the top.
// Depends on fnas_pkg and four_neighbor_average_stencil_macros.svh.
`include "four_neighbor_average_stencil_macros.svh"

module fnas_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int COL_BITS    = 11
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [SAMPLE_BITS+1:0]         average_q2,
    input logic [fnas_pkg::ROW_BITS-1:0]  out_row,
    input logic [COL_BITS-1:0]            out_col,
    input logic                           frame_last
);

    `FNAS_ASSERT_SAME(a_no_idle_stall, clk, rst_n, !(out_valid && out_stall), !in_stall)
    `FNAS_ASSERT_SAME(a_interior_only, clk, rst_n, out_valid, (out_row != '0) && (out_col != '0))
    `FNAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(average_q2) && $stable(out_row) && $stable(out_col) && $stable(frame_last))

endmodule

bind four_neighbor_average_stencil fnas_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_BITS    (COL_BITS)
) u_fnas_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .average_q2 (average_q2),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for four_neighbor_average_stencil.
// Streams grids through the block and checks every average against a built-in
// stencil predictor. Depends on fnas_pkg and the design sources.
module testbench;

    localparam int MAX_W         = 2048;
    localparam int SAMPLE_W      = 16;
    localparam int COL_W         = 11;
    localparam int FILL_W        = 64;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [SAMPLE_W+1:0]           avg;
        logic [fnas_pkg::ROW_BITS-1:0] row;
        logic [COL_W-1:0]              col;
        logic                          last;
    } stencil_out_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_write = 1'b0;
    fnas_pkg::cfg_reg_t                 cfg_index = fnas_pkg::REG_GRID_WIDTH;
    logic [fnas_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [SAMPLE_W-1:0]                sample = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [SAMPLE_W+1:0]                average_q2;
    logic [fnas_pkg::ROW_BITS-1:0]      out_row;
    logic [COL_W-1:0]                   out_col;
    logic                               frame_last;

    // predictor state
    logic [SAMPLE_W-1:0]           older_cells [MAX_W];
    logic [SAMPLE_W-1:0]           newer_cells [MAX_W];
    logic [COL_W-1:0]              next_col = '0;
    logic [fnas_pkg::ROW_BITS-1:0] next_row = '0;
    logic [11:0]                   grid_width_reg = 12'd2048;
    logic [15:0]                   grid_height_reg = 16'd2048;

    logic [SAMPLE_W-1:0] sample_queue [$];
    stencil_out_t        pending_averages [$];

    int sender_gap_pct = 0;
    int receiver_stall_pct = 0;
    int fault_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    four_neighbor_average_stencil dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .average_q2 (average_q2),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

    always #1 clk = ~clk;

    function automatic int eff_width();
        int w;
        w = grid_width_reg;
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = grid_height_reg;
        if (h < 3) h = 3;
        return h;
    endfunction

    // cells still to come before the grid wraps
    function automatic int cells_left();
        int w, h, c, r;
        w = eff_width();
        h = eff_height();
        c = next_col;
        r = next_row;
        if (c > w - 1) c = w - 1;
        if (r >= h - 1) return w - c;
        return (w - c) + (h - 1 - r) * w;
    endfunction

    function automatic void predict_cell(input logic [SAMPLE_W-1:0] s);
        int           w, h, c, r;
        stencil_out_t res;
        w = eff_width();
        h = eff_height();
        c = next_col;
        r = next_row;
        if (c > w - 1) c = w - 1;
        if (r >= 2 && r <= h - 1 && c >= 1 && c <= w - 2) begin
            res.avg  = 18'(older_cells[c]) + 18'(older_cells[c-1])
                     + 18'(newer_cells[c+1]) + 18'(s);
            res.row  = fnas_pkg::ROW_BITS'(r - 1);
            res.col  = COL_W'(c);
            res.last = (r == h - 1 && c == w - 2);
            pending_averages.push_back(res);
        end
        older_cells[c] = newer_cells[c];
        newer_cells[c] = s;
        if (c >= w - 1) begin
            next_col = '0;
            next_row = (r >= h - 1) ? '0 : fnas_pkg::ROW_BITS'(r + 1);
        end
        else begin
            next_col = COL_W'(c + 1);
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic set_idle(input int snd, input int rcv);
        sender_gap_pct = snd;
        receiver_stall_pct = rcv;
    endtask

    task automatic settle();
        while (sample_queue.size() != 0 || in_valid || pending_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input fnas_pkg::cfg_reg_t idx,
                             input logic [fnas_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == fnas_pkg::REG_GRID_WIDTH) grid_width_reg = data[11:0];
        else grid_height_reg = data;
    endtask

    task automatic configure(input bit do_w, input logic [15:0] wdata,
                             input bit do_h, input logic [15:0] hdata);
        settle();
        if (do_w) write_reg(fnas_pkg::REG_GRID_WIDTH, wdata);
        if (do_h) write_reg(fnas_pkg::REG_GRID_HEIGHT, hdata);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // sender: offer queued samples, hold while stalled
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            sample   <= '0;
        end
        else if (in_valid && in_stall) begin
            in_valid <= 1'b1;
        end
        else begin
            if (in_valid) begin
                predict_cell(sample);
                void'(sample_queue.pop_front());
            end
            if (sample_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                in_valid <= 1'b1;
                sample   <= sample_queue[0];
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: check each accepted result, stall at random or hold off
    always @(posedge clk or negedge rst_n) begin
        stencil_out_t want;
        stencil_out_t got;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                got = '{avg: average_q2, row: out_row, col: out_col, last: frame_last};
                if (pending_averages.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: unexpected result avg=%0d row=%0d col=%0d last=%0b",
                                 $realtime, got.avg, got.row, got.col, got.last);
                end
                else begin
                    want = pending_averages.pop_front();
                    if (got.avg !== want.avg || got.row !== want.row
                        || got.col !== want.col || got.last !== want.last) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("%0t: avg/row/col/last exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     $realtime, want.avg, want.row, want.col, want.last,
                                     got.avg, got.row, got.col, got.last);
                    end
                end
                results_seen++;
            end
            if (out_valid && !out_stall && (results_seen == 80 || results_seen == 200)) begin
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int          n;
        int          random_sent;
        logic [15:0] wdata;
        logic [15:0] hdata;
        random_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(30, 73);

        // smallest grid, all samples at full scale
        configure(1, 16'd3, 1, 16'd3);
        repeat (9) sample_queue.push_back('1);

        // out-of-range registers clamp to the smallest grid; walking ones
        configure(1, 16'hF001, 1, 16'd0);
        for (int i = 0; i < 9; i++) sample_queue.push_back(SAMPLE_W'(1) << i);

        // widest grid used below, fills every store entry that later grids read
        configure(1, 16'(FILL_W), 1, 16'd4);
        repeat (4 * FILL_W) sample_queue.push_back(rand_sample());

        // tallest grid, left mid-way for the next register change
        configure(1, 16'h5003, 1, 16'hFFFF);
        repeat (30) sample_queue.push_back(rand_sample());

        while (random_sent < 230) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0: wdata = {4'($urandom), 12'($urandom_range(2))};
                    1: wdata = {4'($urandom), 12'($urandom_range(3, 12))};
                    2: wdata = {4'hF, 12'(FILL_W)};
                    default: wdata = {4'($urandom), 12'($urandom_range(13, FILL_W))};
                endcase
                case ($urandom_range(3))
                    0: hdata = 16'($urandom_range(2));
                    1: hdata = 16'($urandom_range(3, 10));
                    2: hdata = 16'hFFFF;
                    default: hdata = 16'($urandom);
                endcase
                configure($urandom_range(1), wdata, $urandom_range(1), hdata);
                n = $urandom_range(1, 24);
            end
            else begin
                wdata = {4'($urandom), ($urandom_range(5) == 0) ? 12'($urandom_range(2))
                                                                 : 12'($urandom_range(3, 10))};
                hdata = ($urandom_range(5) == 0) ? 16'($urandom_range(2))
                                                 : 16'($urandom_range(3, 7));
                configure(1, wdata, 1, hdata);
                n = cells_left() + $urandom_range(2) * eff_width() * eff_height();
            end
            if (random_sent < 115) set_idle(73, 30);
            else set_idle(0, 0);
            repeat (n) sample_queue.push_back(rand_sample());
            random_sent += n;
        end

        settle();
        repeat (20) @(posedge clk);
        if (fault_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
